### rtl/bounded_set_table_defines.svh
// Assertion macros shared by the bounded set table RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef BOUNDED_SET_TABLE_DEFINES_SVH
`define BOUNDED_SET_TABLE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define BST_ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define BST_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/bst_pkg.sv
// Shared types and constants for the bounded set table.
// No dependencies; used by every module of the block except bst_ram.
package bst_pkg;

    localparam int CAPACITY_DEF  = 16;
    localparam int KEY_WIDTH_DEF = 32;

    localparam int REQ_W     = 2;
    localparam int IN_KEY_W  = 32;
    localparam int SIZE_W    = 5;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 8;

    typedef enum logic [REQ_W-1:0] {
        REQ_INSERT = 2'd0,
        REQ_DELETE = 2'd1,
        REQ_LOOKUP = 2'd2,
        REQ_CLEAR  = 2'd3
    } req_t;

    typedef struct packed {
        logic [SIZE_W-1:0] size;
        logic              present;
        logic              ok;
    } res_t;

endpackage

### rtl/bst_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module bst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/bst_ctrl.sv
// Request sequencer: scans the key store, decides insert/delete/lookup/clear,
// writes back and hands one result per request. Uses bst_pkg and the defines.
`include "bounded_set_table_defines.svh"

module bst_ctrl #(
    parameter int CAPACITY  = bst_pkg::CAPACITY_DEF,
    parameter int KEY_WIDTH = bst_pkg::KEY_WIDTH_DEF,
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
    localparam int CW = $clog2(CAPACITY + 1)
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    // request side
    input  logic                       in_valid,
    output logic                       in_ready,
    input  bst_pkg::req_t              in_req,
    input  logic [KEY_WIDTH-1:0]       in_key,
    // result side
    input  logic                       out_free,
    output logic                       res_valid,
    output bst_pkg::res_t              res,
    // key store
    output logic                       wr_en,
    output logic [AW-1:0]              wr_addr,
    output logic [KEY_WIDTH-1:0]       wr_data,
    output logic                       rd_en,
    output logic [AW-1:0]              rd_addr,
    input  logic [KEY_WIDTH-1:0]       rd_data
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SCAN = 4'b0010,
        ST_LAST = 4'b0100,
        ST_DONE = 4'b1000
    } st_t;

    st_t                  state_reg, state_next;
    bst_pkg::req_t        op_reg, op_next;
    logic [KEY_WIDTH-1:0] key_reg, key_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [CW-1:0]        idx_reg, idx_next;
    logic                 cmp_v_reg, cmp_v_next;
    logic [AW-1:0]        cmp_idx_reg, cmp_idx_next;
    logic [AW-1:0]        slot_reg, slot_next;
    logic                 found_reg, found_next;
    logic                 ok_reg, ok_next;

    logic                 issue;
    logic                 match;
    logic                 last_cmp;
    logic                 done;
    logic [AW-1:0]        tail_addr;

    // read data arrives in the cycle after its address is issued
    assign tail_addr = AW'(count_reg - CW'(1));
    assign match     = cmp_v_reg && (rd_data == key_reg);
    assign last_cmp  = cmp_v_reg && (cmp_idx_reg == tail_addr);
    assign done      = match || last_cmp || (count_reg == '0);
    assign issue     = (state_reg == ST_SCAN) && !done && (idx_reg < count_reg);

    always_comb begin
        state_next   = state_reg;
        op_next      = op_reg;
        key_next     = key_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        cmp_v_next   = 1'b0;
        cmp_idx_next = cmp_idx_reg;
        slot_next    = slot_reg;
        found_next   = found_reg;
        ok_next      = ok_reg;
        in_ready     = 1'b0;
        res_valid    = 1'b0;
        wr_en        = 1'b0;
        wr_addr      = slot_reg;
        wr_data      = rd_data;
        rd_en        = 1'b0;
        rd_addr      = idx_reg[AW-1:0];

        case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    op_next  = in_req;
                    key_next = in_key;
                    idx_next = '0;
                    if (in_req == bst_pkg::REQ_CLEAR) begin
                        count_next = '0;
                        ok_next    = 1'b1;
                        found_next = 1'b0;
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (issue) begin
                    rd_en        = 1'b1;
                    cmp_v_next   = 1'b1;
                    cmp_idx_next = idx_reg[AW-1:0];
                    idx_next     = idx_reg + CW'(1);
                end
                if (done) begin
                    found_next = match;
                    slot_next  = cmp_idx_reg;
                    state_next = ST_DONE;
                    ok_next    = 1'b0;
                    case (op_reg)
                        bst_pkg::REQ_INSERT: begin
                            if (!match && (count_reg < CW'(CAPACITY))) begin
                                wr_en      = 1'b1;
                                wr_addr    = count_reg[AW-1:0];
                                wr_data    = key_reg;
                                count_next = count_reg + CW'(1);
                                ok_next    = 1'b1;
                            end
                        end
                        bst_pkg::REQ_DELETE: begin
                            if (match) begin
                                // fetch the tail entry to move into the hole
                                rd_en      = 1'b1;
                                rd_addr    = tail_addr;
                                count_next = count_reg - CW'(1);
                                ok_next    = 1'b1;
                                state_next = ST_LAST;
                            end
                        end
                        bst_pkg::REQ_LOOKUP: begin
                            ok_next = match;
                        end
                        default: begin
                            ok_next = 1'b0;
                        end
                    endcase
                end
            end
            ST_LAST: begin
                wr_en      = 1'b1;
                wr_addr    = slot_reg;
                wr_data    = rd_data;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    res_valid  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign res.size    = bst_pkg::SIZE_W'(count_reg);
    assign res.present = found_reg;
    assign res.ok      = ok_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            cmp_v_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            cmp_v_reg <= cmp_v_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg      <= op_next;
        key_reg     <= key_next;
        idx_reg     <= idx_next;
        cmp_idx_reg <= cmp_idx_next;
        slot_reg    <= slot_next;
        found_reg   <= found_next;
        ok_reg      <= ok_next;
    end

    `BST_ASSERT_IMPLY(a_count_bound, aclk, aresetn, 1'b1, count_reg <= CW'(CAPACITY), "count above capacity")
    `BST_ASSERT_IMPLY(a_wr_state, aclk, aresetn, wr_en, state_reg == ST_SCAN || state_reg == ST_LAST, "store written outside scan or move")
    `BST_ASSERT_IMPLY(a_cmp_live, aclk, aresetn, state_reg == ST_SCAN && cmp_v_reg, CW'(cmp_idx_reg) < count_reg, "compare beyond live entries")
    `BST_ASSERT_NEXT(a_del_move, aclk, aresetn, state_reg == ST_SCAN && done && match && op_reg == bst_pkg::REQ_DELETE, state_reg == ST_LAST && slot_reg == $past(cmp_idx_reg), "delete did not move tail")
    `BST_ASSERT_IMPLY(a_clear_res, aclk, aresetn, res_valid && op_reg == bst_pkg::REQ_CLEAR, res.size == '0 && res.ok && !res.present, "bad clear result")

endmodule

### rtl/bst_outreg.sv
// Result output register: holds one transfer so the sequencer can move on.
// Uses bst_pkg.
module bst_outreg (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            push,
    input  bst_pkg::res_t                   res,
    output logic                            free,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [bst_pkg::M_TDATA_W-1:0]   m_tdata
);

    logic                          tvalid_reg, tvalid_next;
    logic [bst_pkg::M_TDATA_W-1:0] tdata_reg, tdata_next;

    assign free = !tvalid_reg || m_tready;

    always_comb begin
        tvalid_next = tvalid_reg;
        tdata_next  = tdata_reg;
        if (push) begin
            tvalid_next = 1'b1;
            tdata_next  = bst_pkg::M_TDATA_W'({res.size, res.present, res.ok});
        end else if (m_tready) begin
            tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tvalid_reg <= 1'b0;
        end else begin
            tvalid_reg <= tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        tdata_reg <= tdata_next;
    end

    assign m_tvalid = tvalid_reg;
    assign m_tdata  = tdata_reg;

endmodule

### rtl/bounded_set_table.sv
// Bounded set table top level: key store RAM, request sequencer, output register.
// Uses bst_pkg, bst_ram, bst_ctrl, bst_outreg.
//
//  channel | dir | tdata fields (low bit up)                  | notes
//  s_      | in  | req_type[1:0], key[33:2], zero pad [39:34] | one request per transfer
//  m_      | out | ok[0], present[1], size[6:2], zero pad [7]| one result per request
//
// A request is served by a linear scan of the store through its single read port; a hit
// ends the scan early, a delete that hits adds a step that moves the tail entry into the
// hole, and clear skips the scan.
// Reset (aresetn low, synchronous) empties the set; store contents are not cleared.
// A new request is taken while the previous result still waits in the output register.
// A stalled m_ side holds the finished result and the sequencer waits for the slot.
module bounded_set_table #(
    parameter int CAPACITY  = bst_pkg::CAPACITY_DEF,
    parameter int KEY_WIDTH = bst_pkg::KEY_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [bst_pkg::S_TDATA_W-1:0] s_tdata,  // req_type[1:0], key[33:2]
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [bst_pkg::M_TDATA_W-1:0] m_tdata   // ok, present, size[6:2]
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    bst_pkg::req_t        in_req;
    logic [KEY_WIDTH-1:0] in_key;
    logic                 out_free;
    logic                 res_valid;
    bst_pkg::res_t        res;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [KEY_WIDTH-1:0] wr_data;
    logic                 rd_en;
    logic [AW-1:0]        rd_addr;
    logic [KEY_WIDTH-1:0] rd_data;

    assign in_req = bst_pkg::req_t'(s_tdata[bst_pkg::REQ_W-1:0]);
    // key bits above KEY_WIDTH are dropped, missing ones read as zero
    assign in_key = KEY_WIDTH'(s_tdata[bst_pkg::REQ_W +: bst_pkg::IN_KEY_W]);

    bst_ram #(
        .WIDTH (KEY_WIDTH),
        .DEPTH (CAPACITY)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    bst_ctrl #(
        .CAPACITY  (CAPACITY),
        .KEY_WIDTH (KEY_WIDTH)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_req    (in_req),
        .in_key    (in_key),
        .out_free  (out_free),
        .res_valid (res_valid),
        .res       (res),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data)
    );

    bst_outreg u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (res_valid),
        .res      (res),
        .free     (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
